@@ hw/rtl/imptt_pkg.sv @@
package imptt_pkg;

  // Table geometry.
  localparam int MAX_TASKS = 1024;
  localparam int PRIO_W    = 32;
  localparam int ID_W      = $clog2(MAX_TASKS);

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_EDIT   = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_EXEC   = 2'd3;

  // Input item as it arrives on the command port.
  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  task_id;
    logic [15:0] user_id;
    logic [31:0] priority_req;
  } in_item_t;

  // Result item of an execute-top command.
  typedef struct packed {
    logic [15:0] user_id_out;
    logic        found;
  } out_item_t;

  // One word of the task table memory.
  typedef struct packed {
    logic              valid;
    logic [15:0]       user;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controls from the sequencer to the best-entry tracker.
  typedef struct packed {
    logic            clear;
    logic            sample;
    logic [ID_W-1:0] idx;
  } scan_ctl_t;

endpackage

@@ hw/rtl/indexed_max_priority_task_table.sv @@
// Task table of 1024 entries held in one synchronous memory, with a valid
// mark, a 16-bit user and a 32-bit priority per task. After reset the block
// sweeps the memory to clear every valid mark, and busy stays high during
// the sweep. Add and remove write the memory directly; edit reads the entry,
// then writes it back. Execute-top reads the whole table one entry per cycle
// through the single read port; its result is shown for exactly one cycle on
// out_valid in the same cycle that busy falls.
// The receiver cannot stall, so every result must be captured on its strobe.
// Only execute-top produces a result; found is 0 and the user 0 when the
// table holds no valid task.
module indexed_max_priority_task_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  imptt_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output imptt_pkg::out_item_t out_item
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EDIT  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic [imptt_pkg::ID_W-1:0] LAST_IDX = imptt_pkg::ID_W'(imptt_pkg::MAX_TASKS - 1);

  state_t                         state_r, state_nxt;
  logic [imptt_pkg::ID_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [imptt_pkg::ID_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic [imptt_pkg::ID_W-1:0]     edit_idx_r, edit_idx_nxt;
  logic [imptt_pkg::PRIO_W-1:0]   edit_prio_r, edit_prio_nxt;
  logic                           out_valid_r, out_valid_nxt;
  imptt_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                           mem_we;
  logic [imptt_pkg::ID_W-1:0]     mem_waddr;
  imptt_pkg::entry_t              mem_wdata;
  logic [imptt_pkg::ID_W-1:0]     mem_raddr;
  imptt_pkg::entry_t              mem_rdata;
  logic [imptt_pkg::ENTRY_W-1:0]  mem_rword;

  imptt_pkg::scan_ctl_t           scan_ctl;
  logic                           best_any;
  logic [imptt_pkg::ID_W-1:0]     best_idx;
  logic [15:0]                    best_user;

  logic                           accept;
  logic                           id_in_range;
  logic [imptt_pkg::ID_W-1:0]     in_idx;
  logic [imptt_pkg::PRIO_W-1:0]   in_prio;

  assign accept      = start && !busy;
  assign id_in_range = (32'(in_item.task_id) < 32'(imptt_pkg::MAX_TASKS));
  assign in_idx      = imptt_pkg::ID_W'(in_item.task_id);
  assign in_prio     = imptt_pkg::PRIO_W'(in_item.priority_req);
  assign mem_rdata   = imptt_pkg::entry_t'(mem_rword);

  // Task table storage.
  imptt_ram #(
    .WIDTH (imptt_pkg::ENTRY_W),
    .DEPTH (imptt_pkg::MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rword)
  );

  // Running maximum over the scanned entries.
  imptt_best u_best (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .rd_entry  (mem_rdata),
    .best_any  (best_any),
    .best_idx  (best_idx),
    .best_user (best_user)
  );

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    scan_idx_nxt  = scan_idx_r;
    edit_idx_nxt  = edit_idx_r;
    edit_prio_nxt = edit_prio_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    scan_ctl      = '0;

    case (state_r)
      S_CLEAR: begin
        // Sweep the table once so that no entry reads as valid.
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_item.mode)
            imptt_pkg::MODE_ADD: begin
              if (id_in_range) begin
                mem_we          = 1'b1;
                mem_waddr       = in_idx;
                mem_wdata.valid = 1'b1;
                mem_wdata.user  = in_item.user_id;
                mem_wdata.prio  = in_prio;
              end
            end
            imptt_pkg::MODE_EDIT: begin
              if (id_in_range) begin
                mem_raddr     = in_idx;
                edit_idx_nxt  = in_idx;
                edit_prio_nxt = in_prio;
                state_nxt     = S_EDIT;
              end
            end
            imptt_pkg::MODE_REMOVE: begin
              if (id_in_range) begin
                mem_we    = 1'b1;
                mem_waddr = in_idx;
              end
            end
            imptt_pkg::MODE_EXEC: begin
              mem_raddr      = '0;
              scan_idx_nxt   = '0;
              scan_ctl.clear = 1'b1;
              state_nxt      = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_EDIT: begin
        // Write the new priority back only if the task is present.
        if (mem_rdata.valid) begin
          mem_we          = 1'b1;
          mem_waddr       = edit_idx_r;
          mem_wdata.valid = 1'b1;
          mem_wdata.user  = mem_rdata.user;
          mem_wdata.prio  = edit_prio_r;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        // Data for scan_idx_r is on the read port; fetch the next entry.
        scan_ctl.sample = 1'b1;
        scan_ctl.idx    = scan_idx_r;
        mem_raddr       = scan_idx_r + 1'b1;
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        // Remove the winner and present the result.
        out_valid_nxt = 1'b1;
        if (best_any) begin
          mem_we                   = 1'b1;
          mem_waddr                = best_idx;
          out_item_nxt.found       = 1'b1;
          out_item_nxt.user_id_out = best_user;
        end else begin
          out_item_nxt.found       = 1'b0;
          out_item_nxt.user_id_out = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    edit_idx_r  <= edit_idx_nxt;
    edit_prio_r <= edit_prio_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The block is busy right after reset while the table is cleared.
  assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A result strobe lasts a single cycle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A result only follows the end of a scan.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> $past(state_r == S_DONE))
    else $error("result without a finished scan");

  // An empty result carries a zero user.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && !out_item.found) |-> (out_item.user_id_out == 16'd0))
    else $error("empty result with nonzero user");

  // Busy drops only at the end of clearing, an edit or a scan.
  assert property (@(posedge clk) disable iff (!rst_n)
                   $fell(busy) |-> ($past(state_r == S_CLEAR) || $past(state_r == S_EDIT) ||
                                    $past(state_r == S_DONE)))
    else $error("busy dropped from an unexpected state");

endmodule

@@ hw/rtl/imptt_ram.sv @@
module imptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/imptt_best.sv @@
module imptt_best (
  input  logic                                clk,
  input  logic                                rst_n,
  input  imptt_pkg::scan_ctl_t                ctl,
  input  imptt_pkg::entry_t                   rd_entry,
  output logic                                best_any,
  output logic [imptt_pkg::ID_W-1:0]          best_idx,
  output logic [15:0]                         best_user
);

  logic                         any_r;
  logic [imptt_pkg::ID_W-1:0]   idx_r;
  logic [15:0]                  user_r;
  logic [imptt_pkg::PRIO_W-1:0] prio_r;
  logic                         take;

  // A valid entry replaces the current best when its priority is not smaller.
  // Entries arrive in ascending index order, so the larger index wins a tie.
  assign take = ctl.sample && rd_entry.valid && (!any_r || (rd_entry.prio >= prio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r <= 1'b0;
    end else if (ctl.clear) begin
      any_r <= 1'b0;
    end else if (take) begin
      any_r <= 1'b1;
    end
  end

  // Payload of the current best entry.
  always_ff @(posedge clk) begin
    if (take) begin
      idx_r  <= ctl.idx;
      user_r <= rd_entry.user;
      prio_r <= rd_entry.prio;
    end
  end

  assign best_any  = any_r;
  assign best_idx  = idx_r;
  assign best_user = user_r;

endmodule

@@ tb/indexed_max_priority_task_table_tb.sv @@
`timescale 1ns / 100ps

module indexed_max_priority_task_table_tb;

  localparam int N_RANDOM      = 557;
  localparam int QUIET_TAIL    = 100;
  localparam int DRAIN_CYCLES  = 1100;
  localparam int STALL_LIMIT   = 8000;
  localparam int REPORT_LIMIT  = 10;

  // One directed command, with its result typed in where it is obvious.
  typedef struct {
    imptt_pkg::in_item_t  cmd;
    bit                   typed;
    imptt_pkg::out_item_t res;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  imptt_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  imptt_pkg::out_item_t out_item;

  // Shadow copy of the task table.
  bit          tbl_valid [imptt_pkg::MAX_TASKS];
  logic [15:0] tbl_user  [imptt_pkg::MAX_TASKS];
  logic [31:0] tbl_prio  [imptt_pkg::MAX_TASKS];

  imptt_pkg::out_item_t pending_results[$];
  int                   error_count = 0;
  int                   stall_cycles = 0;

  indexed_max_priority_task_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one command to the shadow table; returns 1 when it yields a result.
  function automatic bit apply_command(input imptt_pkg::in_item_t cmd,
                                       output imptt_pkg::out_item_t res);
    bit          any;
    int          best;
    logic [31:0] best_prio;
    res = '0;
    case (cmd.mode)
      imptt_pkg::MODE_ADD: begin
        tbl_valid[cmd.task_id] = 1'b1;
        tbl_user[cmd.task_id]  = cmd.user_id;
        tbl_prio[cmd.task_id]  = cmd.priority_req;
      end
      imptt_pkg::MODE_EDIT: begin
        if (tbl_valid[cmd.task_id])
          tbl_prio[cmd.task_id] = cmd.priority_req;
      end
      imptt_pkg::MODE_REMOVE: begin
        tbl_valid[cmd.task_id] = 1'b0;
      end
      imptt_pkg::MODE_EXEC: begin
        // Highest priority wins; on a tie the larger task id wins.
        any = 1'b0;
        best = 0;
        best_prio = '0;
        for (int i = 0; i < imptt_pkg::MAX_TASKS; i++) begin
          if (tbl_valid[i] && (!any || tbl_prio[i] >= best_prio)) begin
            any = 1'b1;
            best = i;
            best_prio = tbl_prio[i];
          end
        end
        if (any) begin
          res.user_id_out = tbl_user[best];
          res.found = 1'b1;
          tbl_valid[best] = 1'b0;
        end
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic dir_row_t row(input logic [1:0] mode, input logic [9:0] id,
                                   input logic [15:0] user, input logic [31:0] prio,
                                   input bit typed, input logic [15:0] exp_user,
                                   input logic exp_found);
    dir_row_t r;
    r.cmd.mode = mode;
    r.cmd.task_id = id;
    r.cmd.user_id = user;
    r.cmd.priority_req = prio;
    r.typed = typed;
    r.res.user_id_out = exp_user;
    r.res.found = exp_found;
    return r;
  endfunction

  // Random command; ids cluster at both ends of the table so that edits and
  // removes often hit live entries, and priorities often tie.
  function automatic imptt_pkg::in_item_t random_command();
    imptt_pkg::in_item_t c;
    int                  pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      c.mode = imptt_pkg::MODE_ADD;
    else if (pick < 55)
      c.mode = imptt_pkg::MODE_EDIT;
    else if (pick < 70)
      c.mode = imptt_pkg::MODE_REMOVE;
    else
      c.mode = imptt_pkg::MODE_EXEC;
    case ($urandom_range(0, 3))
      0: c.task_id = 10'($urandom_range(0, imptt_pkg::MAX_TASKS - 1));
      1: c.task_id = 10'($urandom_range(0, 15));
      2: c.task_id = 10'(imptt_pkg::MAX_TASKS - 16 + $urandom_range(0, 15));
      default: c.task_id = 10'($urandom_range(0, 31));
    endcase
    c.user_id = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 5))
      0: c.priority_req = '0;
      1: c.priority_req = '1;
      2, 3: c.priority_req = $urandom_range(0, 7);
      default: c.priority_req = $urandom;
    endcase
    return c;
  endfunction

  task automatic flag_error(input string what);
    if (error_count < REPORT_LIMIT)
      $display("[%0t] %s", $realtime, what);
    error_count++;
  endtask

  // Present one item and hold it until the block takes it.
  task automatic issue_command(input imptt_pkg::in_item_t cmd, input bit typed,
                               input imptt_pkg::out_item_t typed_res);
    imptt_pkg::out_item_t res;
    start <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (apply_command(cmd, res))
      pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 5)) @(posedge clk);
  endtask

  // Hold off the sender until every result is in.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed table first, then random commands.
  initial begin
    dir_row_t             rows[$];
    imptt_pkg::in_item_t  cmd;
    imptt_pkg::out_item_t none;
    bit                   may_idle;

    none = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

    // Empty table, absent edit and remove.
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'h0000, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EDIT, 10'd5, 16'h1111, 32'h0000_0009, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_REMOVE, 10'd7, 16'h2222, 32'h0, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd5, 16'h0000, 32'h0, 1, 16'h0000, 1'b0));
    // Lowest corner of every field.
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd0, 16'h0000, 32'h0, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'h0000, 1'b1));
    // Top priority tie: the larger task id goes first.
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd3, 16'h1234, 32'hFFFF_FFFF, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF,
                       1, 16'hFFFF, 1'b1));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'h1234, 1'b1));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'h0000, 1'b0));
    // Edit lifts a task above another.
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd10, 16'hAAAA, 32'd5, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd20, 16'h5555, 32'd7, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EDIT, 10'd10, 16'h0000, 32'd9, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'hAAAA, 1'b1));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 0, 16'h0, 1'b0));
    // Overwrite by a second add, remove of a live task.
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd30, 16'h0001, 32'd100, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd30, 16'h0002, 32'd1, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd31, 16'h0003, 32'd50, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_REMOVE, 10'd31, 16'h0000, 32'h0, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'h0002, 1'b1));
    // Tie at zero priority between neighbors.
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd0, 16'h0F0F, 32'h0, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_ADD, 10'd1, 16'hF0F0, 32'h0, 0, 16'h0, 1'b0));
    rows.push_back(row(imptt_pkg::MODE_EXEC, 10'd0, 16'h0000, 32'h0, 1, 16'hF0F0, 1'b1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (rows[i]) begin
      issue_command(rows[i].cmd, rows[i].typed, rows[i].res);
      if ($urandom_range(0, 2) == 0)
        idle_burst();
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      // Twice in the run, let every result come home before going on.
      if (k == 200 || k == 400)
        wait_for_results();
      cmd = random_command();
      issue_command(cmd, 1'b0, none);
      may_idle = (k < N_RANDOM - QUIET_TAIL) && ((k / 40) % 3 != 2);
      if (may_idle && $urandom_range(0, 2) == 0)
        idle_burst();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Result checker: every strobe must match the oldest expectation.
  always @(posedge clk) begin
    imptt_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: user=%h found=%b",
                             out_item.user_id_out, out_item.found));
      end else begin
        want = pending_results.pop_front();
        if (out_item.found !== want.found || out_item.user_id_out !== want.user_id_out)
          flag_error($sformatf("result mismatch: expected user=%h found=%b, got user=%h found=%b",
                               want.user_id_out, want.found,
                               out_item.user_id_out, out_item.found));
      end
    end
  end

  // Watchdog on cycles in which no item moves in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", stall_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

@@ indexed_max_priority_task_table.f @@
hw/rtl/imptt_pkg.sv
hw/rtl/imptt_ram.sv
hw/rtl/imptt_best.sv
hw/rtl/indexed_max_priority_task_table.sv
tb/indexed_max_priority_task_table_tb.sv
